// ----- rtl/hsv_palette_color_adjust_unit_assert.svh -----
// assertion macros for the color adjust pipeline
// expects clk and rst_n in the including module
`ifndef HSV_PALETTE_COLOR_ADJUST_UNIT_ASSERT_SVH
`define HSV_PALETTE_COLOR_ADJUST_UNIT_ASSERT_SVH

// same-cycle implication
`define HPCA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpca assertion failed");

// next-cycle implication
`define HPCA_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpca assertion failed");

`endif

// ----- rtl/hpca_pkg.sv -----
// shared types, constants and helper functions for the color adjust pipeline
// no dependencies
`default_nettype none

package hpca_pkg;

    localparam int ONE_Q15             = 32768;
    localparam int HUE_TURN            = 1536;
    localparam int DIV_STAGES          = 8;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int HUE_STEPS           = 9;
    localparam logic [25:0] RECIP_255  = 26'd33686019;
    localparam logic [12:0] RECIP_15   = 13'd4370;

    typedef enum logic [1:0] {
        CFG_BRIGHTNESS = 2'd0,
        CFG_SATURATION = 2'd1,
        CFG_HUE_SHIFT  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [2:0] emphasis_select;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pixel_out_t;

    // divider lanes plus the side data that rides along
    typedef struct packed {
        logic [8:0]  s_rem;
        logic [15:0] s_quo;
        logic [7:0]  s_div;
        logic [8:0]  h_rem;
        logic [8:0]  h_quo;
        logic [7:0]  h_div;
        logic [1:0]  sector;
        logic        diff_neg;
        logic        gray;
        logic [15:0] v;
        logic [2:0]  emph;
    } div_t;

    typedef struct packed {
        logic [16:0] s_mag;
        logic        s_neg;
        logic [10:0] hue;
        logic [16:0] v_adj;
        logic [2:0]  emph;
    } adj_t;

    localparam logic [10:0] GAIN_TABLE [8][3] = '{
        '{11'd1024, 11'd1024, 11'd1024},
        '{11'd1269, 11'd937,  11'd761},
        '{11'd813,  11'd1112, 11'd903},
        '{11'd1043, 11'd1004, 11'd669},
        '{11'd927,  11'd1051, 11'd1308},
        '{11'd1048, 11'd930,  11'd1002},
        '{11'd759,  11'd1011, 11'd1025},
        '{11'd768,  11'd768,  11'd768}
    };

    // one restoring step: {quotient bit, doubled remainder}
    function automatic logic [9:0] div_step(input logic [8:0] rem, input logic [7:0] d);
        logic       take;
        logic [8:0] r;
        take = (rem >= {1'b0, d});
        r    = take ? (rem - {1'b0, d}) : rem;
        return {take, r[7:0], 1'b0};
    endfunction

    // floor(z/255) for z below 65280
    function automatic logic [7:0] div255(input logic [15:0] z);
        logic [16:0] t;
        t = {1'b0, z} + {9'd0, z[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hpca_div.sv -----
// pipelined restoring divider, saturation and hue lanes, two steps per stage
// depends on hpca_pkg
`default_nettype none

module hpca_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          div_in_valid,
    input  wire hpca_pkg::div_t div_in,
    output logic               div_out_valid,
    output hpca_pkg::div_t     div_out
);
    import hpca_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    div_t                  stage_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        div_t stage_src;
        div_t stage_next;
        logic src_valid;

        if (k == 0) begin : g_first
            assign stage_src = div_in;
            assign src_valid = div_in_valid;
        end else begin : g_rest
            assign stage_src = stage_reg[k-1];
            assign src_valid = valid_reg[k-1];
        end

        always_comb begin
            logic [9:0] s_res;
            logic [9:0] h_res;
            stage_next = stage_src;
            s_res      = '0;
            h_res      = '0;
            for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
                s_res            = div_step(stage_next.s_rem, stage_next.s_div);
                stage_next.s_rem = s_res[8:0];
                stage_next.s_quo = {stage_next.s_quo[14:0], s_res[9]};
                // hue lane needs fewer steps, then just rides along
                if (k * DIV_STEPS_PER_STAGE + j < HUE_STEPS) begin
                    h_res            = div_step(stage_next.h_rem, stage_next.h_div);
                    stage_next.h_rem = h_res[8:0];
                    stage_next.h_quo = {stage_next.h_quo[7:0], h_res[9]};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                valid_reg[k] <= 1'b0;
            end else if (adv) begin
                valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge clk) begin
            if (adv) begin
                stage_reg[k] <= stage_next;
            end
        end
    end

    assign div_out_valid = valid_reg[DIV_STAGES-1];
    assign div_out       = stage_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/hpca_adjust.sv -----
// saturation, value and hue adjustment, two register stages
// depends on hpca_pkg
`default_nettype none

module hpca_adjust (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire logic [7:0]     brightness,
    input  wire logic [7:0]     saturation,
    input  wire logic [7:0]     hue_shift,
    input  wire logic           adj_in_valid,
    input  wire hpca_pkg::div_t adj_in,
    output logic                adj_out_valid,
    output hpca_pkg::adj_t      adj_out
);
    import hpca_pkg::*;

    // stage a: hue assembly and shift, value offset, saturation product
    logic [15:0]        s_val;
    logic [8:0]         f_mag;
    logic               f_neg;
    logic [24:0]        s_prod;
    logic signed [11:0] h_raw;
    logic signed [11:0] h_pos;
    logic signed [11:0] h_sh;
    logic signed [11:0] h_wrap;
    logic [8:0]         hd;
    logic               hd_neg;
    logic [8:0]         hd_mag;
    logic [11:0]        deg_x;
    logic [24:0]        off_prod;
    logic [7:0]         off_mag;
    logic signed [11:0] off_s;
    logic [8:0]         bd;
    logic               bd_neg;
    logic [8:0]         bd_mag;
    logic [14:0]        b128;
    logic [15:0]        b_off;
    logic [16:0]        v_adj;

    always_comb begin
        s_val  = adj_in.gray ? 16'd0 : adj_in.s_quo;
        f_neg  = (saturation == 8'd0);
        f_mag  = f_neg ? 9'd1 : ({saturation, 1'b0} - 9'd1);
        s_prod = s_val * f_mag;

        // hue in 1/256 sector units
        if (adj_in.gray) begin
            h_raw = '0;
        end else if (adj_in.diff_neg) begin
            h_raw = $signed({1'b0, adj_in.sector, 9'd0}) - $signed({3'd0, adj_in.h_quo});
        end else begin
            h_raw = $signed({1'b0, adj_in.sector, 9'd0}) + $signed({3'd0, adj_in.h_quo});
        end
        h_pos = h_raw[11] ? (h_raw + 12'sd1536) : h_raw;

        // offset: trunc(trunc((hs-128)/4) * 64 / 15)
        hd       = {1'b0, hue_shift} - 9'd128;
        hd_neg   = hd[8];
        hd_mag   = hd_neg ? (9'd0 - hd) : hd;
        deg_x    = {hd_mag[7:2], 6'd0};
        off_prod = deg_x * RECIP_15;
        off_mag  = off_prod[23:16];
        off_s    = hd_neg ? -$signed({4'd0, off_mag}) : $signed({4'd0, off_mag});

        h_sh = h_pos - off_s;
        if (h_sh >= 12'sd1536) begin
            h_wrap = h_sh - 12'sd1536;
        end else if (h_sh < 12'sd0) begin
            h_wrap = h_sh + 12'sd1536;
        end else begin
            h_wrap = h_sh;
        end

        // value offset trunc((b-128)*32768/255)
        bd     = {1'b0, brightness} - 9'd128;
        bd_neg = bd[8];
        bd_mag = bd_neg ? (9'd0 - bd) : bd;
        b128   = {bd_mag[7:0], 7'd0};
        b_off  = {1'b0, b128} + {8'd0, div255({1'b0, b128})};
        v_adj  = bd_neg ? ({1'b0, adj_in.v} - {1'b0, b_off})
                        : ({1'b0, adj_in.v} + {1'b0, b_off});
    end

    logic        a_valid_reg;
    logic [24:0] a_sprod_reg;
    logic        a_fneg_reg;
    logic [10:0] a_hue_reg;
    logic [16:0] a_vadj_reg;
    logic [2:0]  a_emph_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_valid_reg   <= 1'b0;
            adj_out_valid <= 1'b0;
        end else if (adv) begin
            a_valid_reg   <= adj_in_valid;
            adj_out_valid <= a_valid_reg;
        end
    end

    // stage b: divide the saturation product by 255 through a reciprocal
    logic [50:0] recip_prod;
    assign recip_prod = a_sprod_reg * RECIP_255;

    always_ff @(posedge clk) begin
        if (adv) begin
            a_sprod_reg   <= s_prod;
            a_fneg_reg    <= f_neg;
            a_hue_reg     <= h_wrap[10:0];
            a_vadj_reg    <= v_adj;
            a_emph_reg    <= adj_in.emph;
            adj_out.s_mag <= recip_prod[49:33];
            adj_out.s_neg <= a_fneg_reg;
            adj_out.hue   <= a_hue_reg;
            adj_out.v_adj <= a_vadj_reg;
            adj_out.emph  <= a_emph_reg;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hpca_rgb.sv -----
// hsv to rgb, emphasis gain and byte clamp, six register stages
// depends on hpca_pkg
`default_nettype none

module hpca_rgb (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire logic           rgb_in_valid,
    input  wire hpca_pkg::adj_t rgb_in,
    output logic                rgb_out_valid,
    output hpca_pkg::pixel_out_t rgb_out
);
    import hpca_pkg::*;

    function automatic logic signed [17:0] trunc_q15(input logic signed [34:0] x);
        logic signed [34:0] t;
        t = x[34] ? (x + 35'sd32767) : x;
        t = t >>> 15;
        return t[17:0];
    endfunction

    function automatic logic [7:0] to_byte(input logic pos, input logic [27:0] prod);
        logic [35:0] y;
        y = {prod, 8'd0} - {8'd0, prod};
        if (!pos) begin
            return 8'd0;
        end else if (y[35:25] > 11'd255) begin
            return 8'd255;
        end else begin
            return y[32:25];
        end
    endfunction

    logic [5:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[4:0], rgb_in_valid};
        end
    end
    assign rgb_out_valid = valid_reg[5];

    // stage d: signed saturation times hue fraction
    logic signed [17:0] s_adj;
    logic [7:0]         f_in;
    logic [8:0]         g_in;
    assign s_adj = rgb_in.s_neg ? -$signed({1'b0, rgb_in.s_mag}) : $signed({1'b0, rgb_in.s_mag});
    assign f_in  = rgb_in.hue[7:0];
    assign g_in  = 9'd256 - {1'b0, f_in};

    logic signed [27:0] d_sf_reg;
    logic signed [27:0] d_sg_reg;
    logic signed [17:0] d_s_reg;
    logic signed [16:0] d_v_reg;
    logic [2:0]         d_sec_reg;
    logic [2:0]         d_emph_reg;

    always_ff @(posedge clk) begin
        if (adv) begin
            d_sf_reg   <= s_adj * $signed({2'b0, f_in});
            d_sg_reg   <= s_adj * $signed({1'b0, g_in});
            d_s_reg    <= s_adj;
            d_v_reg    <= $signed(rgb_in.v_adj);
            d_sec_reg  <= rgb_in.hue[10:8];
            d_emph_reg <= rgb_in.emph;
        end
    end

    // stage e: one minus the scaled saturation, truncated toward zero
    logic signed [27:0] tf;
    logic signed [27:0] tg;
    logic signed [27:0] fac_q;
    logic signed [27:0] fac_t;
    assign tf    = (d_sf_reg[27] ? (d_sf_reg + 28'sd255) : d_sf_reg) >>> 8;
    assign tg    = (d_sg_reg[27] ? (d_sg_reg + 28'sd255) : d_sg_reg) >>> 8;
    assign fac_q = 28'sd32768 - tf;
    assign fac_t = 28'sd32768 - tg;

    logic signed [17:0] e_fp_reg;
    logic signed [17:0] e_fq_reg;
    logic signed [17:0] e_ft_reg;
    logic signed [16:0] e_v_reg;
    logic [2:0]         e_sec_reg;
    logic [2:0]         e_emph_reg;

    always_ff @(posedge clk) begin
        if (adv) begin
            e_fp_reg   <= 18'sd32768 - d_s_reg;
            e_fq_reg   <= fac_q[17:0];
            e_ft_reg   <= fac_t[17:0];
            e_v_reg    <= d_v_reg;
            e_sec_reg  <= d_sec_reg;
            e_emph_reg <= d_emph_reg;
        end
    end

    // stage f: value times the three factors
    logic signed [34:0] f_p_reg;
    logic signed [34:0] f_q_reg;
    logic signed [34:0] f_t_reg;
    logic signed [16:0] f_v_reg;
    logic [2:0]         f_sec_reg;
    logic [2:0]         f_emph_reg;

    always_ff @(posedge clk) begin
        if (adv) begin
            f_p_reg    <= e_v_reg * e_fp_reg;
            f_q_reg    <= e_v_reg * e_fq_reg;
            f_t_reg    <= e_v_reg * e_ft_reg;
            f_v_reg    <= e_v_reg;
            f_sec_reg  <= e_sec_reg;
            f_emph_reg <= e_emph_reg;
        end
    end

    // stage g: back to q1.15 and route by sector
    logic signed [17:0] cp;
    logic signed [17:0] cq;
    logic signed [17:0] ct;
    logic signed [17:0] cv;
    logic signed [17:0] c_r;
    logic signed [17:0] c_g;
    logic signed [17:0] c_b;

    always_comb begin
        cp = trunc_q15(f_p_reg);
        cq = trunc_q15(f_q_reg);
        ct = trunc_q15(f_t_reg);
        cv = {f_v_reg[16], f_v_reg};
        case (f_sec_reg)
            3'd0: begin c_r = cv; c_g = ct; c_b = cp; end
            3'd1: begin c_r = cq; c_g = cv; c_b = cp; end
            3'd2: begin c_r = cp; c_g = cv; c_b = ct; end
            3'd3: begin c_r = cp; c_g = cq; c_b = cv; end
            3'd4: begin c_r = ct; c_g = cp; c_b = cv; end
            default: begin c_r = cv; c_g = cp; c_b = cq; end
        endcase
    end

    logic signed [17:0] g_r_reg;
    logic signed [17:0] g_g_reg;
    logic signed [17:0] g_b_reg;
    logic [2:0]         g_emph_reg;

    always_ff @(posedge clk) begin
        if (adv) begin
            g_r_reg    <= c_r;
            g_g_reg    <= c_g;
            g_b_reg    <= c_b;
            g_emph_reg <= f_emph_reg;
        end
    end

    // stage h: emphasis gain
    logic [27:0] h_r_reg;
    logic [27:0] h_g_reg;
    logic [27:0] h_b_reg;
    logic [2:0]  h_pos_reg;

    always_ff @(posedge clk) begin
        if (adv) begin
            h_r_reg   <= g_r_reg[16:0] * GAIN_TABLE[g_emph_reg][0];
            h_g_reg   <= g_g_reg[16:0] * GAIN_TABLE[g_emph_reg][1];
            h_b_reg   <= g_b_reg[16:0] * GAIN_TABLE[g_emph_reg][2];
            h_pos_reg <= {g_r_reg > 18'sd0, g_g_reg > 18'sd0, g_b_reg > 18'sd0};
        end
    end

    // stage i: times 255, drop 25 bits, clamp; this is the output register
    always_ff @(posedge clk) begin
        if (adv) begin
            rgb_out.red_out   <= to_byte(h_pos_reg[2], h_r_reg);
            rgb_out.green_out <= to_byte(h_pos_reg[1], h_g_reg);
            rgb_out.blue_out  <= to_byte(h_pos_reg[0], h_b_reg);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hsv_palette_color_adjust_unit.sv -----
// hsv color adjust with emphasis gain, top level; uses hpca_pkg, hpca_div,
// hpca_adjust, hpca_rgb and the assertion header
// path: an accepted pixel beat passes the front stage, hpca_div, hpca_adjust and hpca_rgb to its result beat
// throughput: one pixel beat per cycle; the whole 17-stage pipeline holds while
// a result beat waits unaccepted, set by the single shared advance enable
// reset: async active low, clears valid bits and sets all three settings to 128
`default_nettype none

`include "hsv_palette_color_adjust_unit_assert.svh"

module hsv_palette_color_adjust_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pixel_valid,
    output logic                      pixel_ready,
    input  wire hpca_pkg::pixel_in_t  pixel,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output hpca_pkg::pixel_out_t      result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [7:0]           cfg_data
);
    import hpca_pkg::*;

    // settings registers, written any time the port offers a beat
    logic [7:0] brightness_reg;
    logic [7:0] saturation_reg;
    logic [7:0] hue_shift_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            brightness_reg <= 8'd128;
            saturation_reg <= 8'd128;
            hue_shift_reg  <= 8'd128;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BRIGHTNESS: brightness_reg <= cfg_data;
                CFG_SATURATION: saturation_reg <= cfg_data;
                CFG_HUE_SHIFT:  hue_shift_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // every stage moves together; the pipeline holds only when the output
    // register is full and the sink is not taking it
    logic adv;
    logic accept;
    assign adv         = !result_valid || result_ready;
    assign pixel_ready = adv;
    assign accept      = pixel_valid && pixel_ready;

    // front stage: max/min, sector, hue difference and value
    logic [7:0]  c_r;
    logic [7:0]  c_g;
    logic [7:0]  c_b;
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  delta;
    logic [1:0]  sector;
    logic [8:0]  diff;
    logic        diff_neg;
    logic [8:0]  diff_mag;
    logic [14:0] mx128;
    logic [15:0] v_q15;
    div_t        front_next;

    always_comb begin
        c_r = pixel.red_in;
        c_g = pixel.green_in;
        c_b = pixel.blue_in;
        mx  = c_r;
        if (c_g > mx) mx = c_g;
        if (c_b > mx) mx = c_b;
        mn  = c_r;
        if (c_g < mn) mn = c_g;
        if (c_b < mn) mn = c_b;
        delta = mx - mn;

        // first maximal channel in red, green, blue order picks the sector
        if (c_r == mx) begin
            sector = 2'd0;
            diff   = {1'b0, c_g} - {1'b0, c_b};
        end else if (c_g == mx) begin
            sector = 2'd1;
            diff   = {1'b0, c_b} - {1'b0, c_r};
        end else begin
            sector = 2'd2;
            diff   = {1'b0, c_r} - {1'b0, c_g};
        end
        diff_neg = diff[8];
        diff_mag = diff_neg ? (9'd0 - diff) : diff;

        // ceil(mx*32768/255) = mx*128 + ceil(mx*128/255)
        mx128 = {mx, 7'd0};
        v_q15 = {1'b0, mx128} + {8'd0, div255({1'b0, mx128} + 16'd254)};

        front_next.s_rem    = {1'b0, delta};
        front_next.s_quo    = '0;
        front_next.s_div    = mx;
        front_next.h_rem    = {1'b0, diff_mag[7:0]};
        front_next.h_quo    = '0;
        front_next.h_div    = delta;
        front_next.sector   = sector;
        front_next.diff_neg = diff_neg;
        front_next.gray     = (delta == 8'd0);
        front_next.v        = v_q15;
        front_next.emph     = pixel.emphasis_select;
    end

    logic front_valid_reg;
    div_t front_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            front_valid_reg <= 1'b0;
        end else if (adv) begin
            front_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            front_reg <= front_next;
        end
    end

    // 8 stages: saturation quotient and hue fraction
    logic div_valid;
    div_t div_data;

    hpca_div u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .div_in_valid  (front_valid_reg),
        .div_in        (front_reg),
        .div_out_valid (div_valid),
        .div_out       (div_data)
    );

    // 2 stages: apply the three settings
    logic adj_valid;
    adj_t adj_data;

    hpca_adjust u_adjust (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .brightness    (brightness_reg),
        .saturation    (saturation_reg),
        .hue_shift     (hue_shift_reg),
        .adj_in_valid  (div_valid),
        .adj_in        (div_data),
        .adj_out_valid (adj_valid),
        .adj_out       (adj_data)
    );

    // 6 stages: back to rgb, gain, clamp; last stage is the output register
    hpca_rgb u_rgb (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .rgb_in_valid  (adj_valid),
        .rgb_in        (adj_data),
        .rgb_out_valid (result_valid),
        .rgb_out       (result)
    );

    // an accepted beat always lands in the front stage
    `HPCA_ASSERT_NXT(a_accept_to_front, accept, front_valid_reg)
    // a held pipeline keeps the divider output in place
    `HPCA_ASSERT_NXT(a_stall_holds_div, !adv, $stable(div_valid) && $stable(div_data))
    // delta never exceeds max, so the saturation quotient stays within one
    `HPCA_ASSERT_IMP(a_delta_le_max, front_valid_reg,
                     front_reg.s_rem <= {1'b0, front_reg.s_div})

endmodule

`default_nettype wire

// ----- dv/hsv_palette_color_adjust_unit_test.sv -----
// testbench for the hsv color adjust unit: random and directed pixel beats,
// settings writes between phases, results checked against a local predictor
// depends on hpca_pkg and hsv_palette_color_adjust_unit
`timescale 1ns / 100ps

module hsv_palette_color_adjust_unit_test;
    import hpca_pkg::*;

    // per-channel emphasis gains, q2.10
    localparam int EMPH_GAIN [8][3] = '{
        '{1024, 1024, 1024}, '{1269, 937, 761}, '{813, 1112, 903},
        '{1043, 1004, 669}, '{927, 1051, 1308}, '{1048, 930, 1002},
        '{759, 1011, 1025}, '{768, 768, 768}
    };
    localparam int Q15 = 32768;
    localparam int TURN = 1536;
    localparam int PIPE_DEPTH = 17;
    localparam longint CYCLE_LIMIT = 400000;

    // clamped channel from a q1.15 value and a q2.10 gain
    function automatic logic [7:0] chan_byte(int c, int g);
        longint x;
        x = longint'(c) * g * 255;
        if (x <= 0)
            return 8'd0;
        x = x / (longint'(1) << 25);
        return (x > 255) ? 8'd255 : x[7:0];
    endfunction

    // predicted adjusted pixel for the given settings
    function automatic pixel_out_t adjust_pixel(pixel_in_t px, int bri, int sat, int hsh);
        int r, g, b, mx, mn, v, s, h, d, deg, off, sec, f, p, q, t, cr, cg, cb;
        pixel_out_t o;
        r = int'(px.red_in);
        g = int'(px.green_in);
        b = int'(px.blue_in);
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        v = (mx * Q15 + 254) / 255;
        s = 0;
        h = 0;
        d = mx - mn;
        if (mx != 0 && d != 0) begin
            s = (d * Q15) / mx;
            if (r == mx)
                h = ((g - b) * 256) / d;
            else if (g == mx)
                h = 512 + ((b - r) * 256) / d;
            else
                h = 1024 + ((r - g) * 256) / d;
            if (h < 0)
                h += TURN;
        end
        s = int'((longint'(s) * (2 * sat - 1)) / 255);
        v = v + ((bri - 128) * Q15) / 255;
        deg = (hsh - 128) / 4;
        off = (deg * 256) / 60;
        h -= off;
        if (h >= TURN)
            h -= TURN;
        else if (h < 0)
            h += TURN;
        if (s == 0) begin
            cr = v; cg = v; cb = v;
        end
        else begin
            sec = h / 256;
            f = h % 256;
            p = int'((longint'(v) * (Q15 - s)) / Q15);
            q = int'((longint'(v) * (Q15 - (s * f) / 256)) / Q15);
            t = int'((longint'(v) * (Q15 - (s * (256 - f)) / 256)) / Q15);
            case (sec)
                0: begin cr = v; cg = t; cb = p; end
                1: begin cr = q; cg = v; cb = p; end
                2: begin cr = p; cg = v; cb = t; end
                3: begin cr = p; cg = q; cb = v; end
                4: begin cr = t; cg = p; cb = v; end
                default: begin cr = v; cg = p; cb = q; end
            endcase
        end
        o.red_out   = chan_byte(cr, EMPH_GAIN[px.emphasis_select][0]);
        o.green_out = chan_byte(cg, EMPH_GAIN[px.emphasis_select][1]);
        o.blue_out  = chan_byte(cb, EMPH_GAIN[px.emphasis_select][2]);
        return o;
    endfunction

    // holds the settings shadow and the expected pixel queue
    class pixel_scoreboard;
        int bri = 128;
        int sat = 128;
        int hsh = 128;
        pixel_out_t pending[$];
        int errors = 0;

        function void note_pixel(pixel_in_t px);
            pending.push_back(adjust_pixel(px, bri, sat, hsh));
        endfunction

        function void check_result(pixel_out_t got);
            pixel_out_t want;
            if (pending.size() == 0) begin
                $error("unexpected result beat %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.red_out !== want.red_out) begin
                $error("red_out expected %0d actual %0d", want.red_out, got.red_out);
                errors++;
            end
            if (got.green_out !== want.green_out) begin
                $error("green_out expected %0d actual %0d", want.green_out, got.green_out);
                errors++;
            end
            if (got.blue_out !== want.blue_out) begin
                $error("blue_out expected %0d actual %0d", want.blue_out, got.blue_out);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pixel_valid = 1'b0;
    logic pixel_ready;
    pixel_in_t pixel = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    pixel_out_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    pixel_scoreboard board = new();
    longint cycles = 0;
    bit quiet = 1'b0;       // no idling in the last part
    bit hold_sink = 1'b0;   // long receiver hold-off request

    hsv_palette_color_adjust_unit dut (
        .clk(clk), .rst_n(rst_n),
        .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: check each accepted beat, stall in random bursts
    initial
    begin : sink
        int idle;
        idle = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (result_valid && result_ready)
                board.check_result(result);
            if (hold_sink) begin
                // long hold-off so the pipeline fills and stalls the input
                result_ready <= 1'b0;
                repeat (60) @(posedge clk);
                hold_sink = 1'b0;
                idle = 0;
            end
            else if (idle > 0) begin
                idle--;
                result_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0) begin
                idle = $urandom_range(1, 11) - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // one pixel beat, with an optional random gap first
    task automatic send_pixel(pixel_in_t px);
        if (!quiet && $urandom_range(0, 6) == 0) begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel <= px;
        do @(posedge clk); while (!pixel_ready);
        board.note_pixel(px);
    endtask

    task automatic wait_drained();
        pixel_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 3) @(posedge clk);
    endtask

    // settings write while the pipeline is empty; the caller drops cfg_valid
    task automatic write_setting(cfg_index_t idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_BRIGHTNESS: board.bri = int'(val);
            CFG_SATURATION: board.sat = int'(val);
            default:        board.hsh = int'(val);
        endcase
    endtask

    function automatic pixel_in_t rand_pixel();
        pixel_in_t px;
        px.red_in = 8'($urandom);
        px.green_in = 8'($urandom);
        px.blue_in = 8'($urandom);
        px.emphasis_select = 3'($urandom);
        // some gray colors
        if ($urandom_range(0, 9) == 0) begin
            px.green_in = px.red_in;
            px.blue_in = px.red_in;
        end
        return px;
    endfunction

    initial
    begin : source
        logic [7:0] set_vals[6];
        set_vals = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd200, 8'd60};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: black, white, primaries, ties, every emphasis row
        send_pixel('{8'd0, 8'd0, 8'd0, 3'd0});
        send_pixel('{8'd255, 8'd255, 8'd255, 3'd7});
        send_pixel('{8'd255, 8'd0, 8'd0, 3'd1});
        send_pixel('{8'd0, 8'd255, 8'd0, 3'd2});
        send_pixel('{8'd0, 8'd0, 8'd255, 3'd3});
        send_pixel('{8'd255, 8'd255, 8'd0, 3'd4});
        send_pixel('{8'd0, 8'd255, 8'd255, 3'd5});
        send_pixel('{8'd255, 8'd0, 8'd255, 3'd6});
        send_pixel('{8'd128, 8'd128, 8'd128, 3'd4});
        send_pixel('{8'd1, 8'd0, 8'd0, 3'd0});
        send_pixel('{8'd200, 8'd100, 8'd150, 3'd1});
        wait_drained();

        // setting phases, fixed values including extremes first, then random values
        for (int ph = 0; ph < 12; ph++) begin
            if (ph < 6) begin
                write_setting(CFG_BRIGHTNESS, set_vals[ph]);
                write_setting(CFG_SATURATION, set_vals[(ph + 1) % 6]);
                write_setting(CFG_HUE_SHIFT, set_vals[(ph + 2) % 6]);
            end
            else begin
                write_setting(CFG_BRIGHTNESS, 8'($urandom));
                write_setting(CFG_SATURATION, 8'($urandom));
                write_setting(CFG_HUE_SHIFT, 8'($urandom));
            end
            cfg_valid <= 1'b0;
            if (ph == 10)
                quiet = 1'b1;
            if (ph == 3)
                hold_sink = 1'b1;
            for (int k = 0; k < 150; k++)
                send_pixel(rand_pixel());
            // sender pause until all results are back
            wait_drained();
        end

        repeat (PIPE_DEPTH * 4) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/hpca_pkg.sv
rtl/hpca_div.sv
rtl/hpca_adjust.sv
rtl/hpca_rgb.sv
rtl/hsv_palette_color_adjust_unit.sv
dv/hsv_palette_color_adjust_unit_test.sv
